>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros used by the checker module
// Clocked concurrent assertions, with and without reset qualification.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every rising edge of clk while rst_n is high.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check on every rising edge of clk, reset included.
`define ASSERT_CLK_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/qirsc_pkg.sv
// ----------------------------------------------------------------------------
// qirsc_pkg
// Shared widths, reset values and codes of the inverse quaternion rotator.
// ----------------------------------------------------------------------------
`default_nettype none

package qirsc_pkg;

  localparam int DATA_W          = 16;
  localparam int CMD_W           = 2;
  localparam int SCALE_W         = 16;
  localparam int CLIP_W          = 15;
  localparam int CFG_IDX_W       = 2;
  localparam int SCALE_FRAC_BITS = 12;
  localparam int QUAT_FRAC_DEF   = 14;

  localparam logic [SCALE_W-1:0] LIN_VEL_SCALE_RST = 16'd8192;
  localparam logic [SCALE_W-1:0] ANG_VEL_SCALE_RST = 16'd1024;
  localparam logic [CLIP_W-1:0]  CLIP_LIMIT_RST    = 15'd25600;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LIN_VEL_SCALE = 2'd0,
    CFG_ANG_VEL_SCALE = 2'd1,
    CFG_CLIP_LIMIT    = 2'd2
  } cfg_idx_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_LIN_VEL = 2'd0,
    CMD_ANG_VEL = 2'd1,
    CMD_GRAVITY = 2'd2
  } cmd_t;

endpackage

`default_nettype wire

>>> hw/rtl/quat_inverse_rotate_scale_clip.sv
// ----------------------------------------------------------------------------
// quat_inverse_rotate_scale_clip
// Rotates a Q7.8 vector into the body frame by the inverse of a Q2.14 unit
// quaternion, scales it per kind, clamps it to +/- clip_limit.
// ----------------------------------------------------------------------------
// Six-stage pipeline that takes one item per clock while in_stall is low.
// Stages: 16x16 products, cross/dot/w^2 sums, wide products, round and
// subtract v, scale product, round and clamp. Each stage holds its item while
// the next one is full and cannot pass its own item on, so bubbles close up
// and in_stall rises only when all six stages hold items. Configuration
// writes take effect at once; cfg_ready is always high.
// ----------------------------------------------------------------------------
`default_nettype none

module quat_inverse_rotate_scale_clip #(
  parameter int QUAT_FRAC_BITS = qirsc_pkg::QUAT_FRAC_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // input channel
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [qirsc_pkg::CMD_W-1:0]      in_cmd,
  input  wire logic signed [qirsc_pkg::DATA_W-1:0] in_quat_x,
  input  wire logic signed [qirsc_pkg::DATA_W-1:0] in_quat_y,
  input  wire logic signed [qirsc_pkg::DATA_W-1:0] in_quat_z,
  input  wire logic signed [qirsc_pkg::DATA_W-1:0] in_quat_w,
  input  wire logic signed [qirsc_pkg::DATA_W-1:0] in_vec_x,
  input  wire logic signed [qirsc_pkg::DATA_W-1:0] in_vec_y,
  input  wire logic signed [qirsc_pkg::DATA_W-1:0] in_vec_z,
  // configuration
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [qirsc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [qirsc_pkg::SCALE_W-1:0]    cfg_data,
  // result channel
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic signed [qirsc_pkg::DATA_W-1:0]   out_x,
  output logic signed [qirsc_pkg::DATA_W-1:0]   out_y,
  output logic signed [qirsc_pkg::DATA_W-1:0]   out_z,
  output logic                                  out_clipped
);

  import qirsc_pkg::*;

  localparam int NSTG    = 6;
  localparam int P1_W    = 2 * DATA_W;          // 16x16 products
  localparam int CR_W    = P1_W + 1;            // cross terms, 2*w^2
  localparam int DOT_W   = P1_W + 2;
  localparam int PA_W    = DATA_W + CR_W;       // v*2w^2, w*cr
  localparam int PC_W    = DATA_W + DOT_W;      // qv*dot
  localparam int ROT_SH  = 2 * QUAT_FRAC_BITS;
  localparam int SUM_W   = (ROT_SH + 4 > 52) ? ROT_SH + 4 : 52;
  localparam int SH_W    = (SUM_W - ROT_SH > DATA_W) ? SUM_W - ROT_SH : DATA_W;
  localparam int ROT_W   = SH_W + 1;
  localparam int SCL_W   = SCALE_W + 1;
  localparam int PROD_W  = ROT_W + SCL_W;
  localparam logic signed [SUM_W-1:0]  ROT_HALF  = SUM_W'(1) << (ROT_SH - 1);
  localparam logic signed [PROD_W-1:0] SCL_HALF  = PROD_W'(1) << (SCALE_FRAC_BITS - 1);
  localparam logic signed [SCL_W-1:0]  SCL_UNITY = SCL_W'(1) << SCALE_FRAC_BITS;

  // ---------------- configuration registers ----------------
  logic [SCALE_W-1:0] lin_scale_r;
  logic [SCALE_W-1:0] ang_scale_r;
  logic [CLIP_W-1:0]  clip_lim_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lin_scale_r <= LIN_VEL_SCALE_RST;
      ang_scale_r <= ANG_VEL_SCALE_RST;
      clip_lim_r  <= CLIP_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_LIN_VEL_SCALE: lin_scale_r <= cfg_data;
        CFG_ANG_VEL_SCALE: ang_scale_r <= cfg_data;
        CFG_CLIP_LIMIT:    clip_lim_r  <= cfg_data[CLIP_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- pipeline flow control ----------------
  logic [NSTG-1:0] vld_r;
  logic [NSTG-1:0] vld_nxt;
  logic [NSTG-1:0] rdy;

  always_comb begin
    rdy[NSTG-1] = !vld_r[NSTG-1] || !out_stall;
    for (int k = NSTG - 2; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
    vld_nxt = vld_r;
    if (rdy[0]) begin
      vld_nxt[0] = in_valid;
    end
    for (int k = 1; k < NSTG; k++) begin
      if (rdy[k]) begin
        vld_nxt[k] = vld_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_stall  = !rdy[0];
  assign out_valid = vld_r[NSTG-1];

  // ---------------- stage 1: narrow products ----------------
  logic signed [P1_W-1:0]   p_yz_r, p_zy_r, p_zx_r, p_xz_r, p_xy_r, p_yx_r;
  logic signed [P1_W-1:0]   d_x_r, d_y_r, d_z_r, ww_r;
  logic signed [DATA_W-1:0] s1_q_r [4];
  logic signed [DATA_W-1:0] s1_v_r [3];
  logic [CMD_W-1:0]         s1_cmd_r;

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      p_yz_r    <= P1_W'(in_quat_y) * P1_W'(in_vec_z);
      p_zy_r    <= P1_W'(in_quat_z) * P1_W'(in_vec_y);
      p_zx_r    <= P1_W'(in_quat_z) * P1_W'(in_vec_x);
      p_xz_r    <= P1_W'(in_quat_x) * P1_W'(in_vec_z);
      p_xy_r    <= P1_W'(in_quat_x) * P1_W'(in_vec_y);
      p_yx_r    <= P1_W'(in_quat_y) * P1_W'(in_vec_x);
      d_x_r     <= P1_W'(in_quat_x) * P1_W'(in_vec_x);
      d_y_r     <= P1_W'(in_quat_y) * P1_W'(in_vec_y);
      d_z_r     <= P1_W'(in_quat_z) * P1_W'(in_vec_z);
      ww_r      <= P1_W'(in_quat_w) * P1_W'(in_quat_w);
      s1_q_r[0] <= in_quat_x;
      s1_q_r[1] <= in_quat_y;
      s1_q_r[2] <= in_quat_z;
      s1_q_r[3] <= in_quat_w;
      s1_v_r[0] <= in_vec_x;
      s1_v_r[1] <= in_vec_y;
      s1_v_r[2] <= in_vec_z;
      s1_cmd_r  <= in_cmd;
    end
  end

  // ---------------- stage 2: cross, dot, 2w^2 ----------------
  logic signed [CR_W-1:0]   cr_r [3];
  logic signed [DOT_W-1:0]  dot_r;
  logic signed [CR_W-1:0]   w2x2_r;
  logic signed [DATA_W-1:0] s2_q_r [4];
  logic signed [DATA_W-1:0] s2_v_r [3];
  logic [CMD_W-1:0]         s2_cmd_r;

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      cr_r[0]  <= CR_W'(p_yz_r) - CR_W'(p_zy_r);
      cr_r[1]  <= CR_W'(p_zx_r) - CR_W'(p_xz_r);
      cr_r[2]  <= CR_W'(p_xy_r) - CR_W'(p_yx_r);
      dot_r    <= DOT_W'(d_x_r) + DOT_W'(d_y_r) + DOT_W'(d_z_r);
      w2x2_r   <= CR_W'(ww_r) <<< 1;
      s2_q_r   <= s1_q_r;
      s2_v_r   <= s1_v_r;
      s2_cmd_r <= s1_cmd_r;
    end
  end

  // ---------------- stage 3: wide products ----------------
  logic signed [PA_W-1:0]   pa_r [3];
  logic signed [PA_W-1:0]   pb_r [3];
  logic signed [PC_W-1:0]   pc_r [3];
  logic signed [DATA_W-1:0] s3_v_r [3];
  logic [CMD_W-1:0]         s3_cmd_r;

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      for (int i = 0; i < 3; i++) begin
        pa_r[i] <= PA_W'(s2_v_r[i]) * PA_W'(w2x2_r);
        pb_r[i] <= PA_W'(s2_q_r[3]) * PA_W'(cr_r[i]);
        pc_r[i] <= PC_W'(s2_q_r[i]) * PC_W'(dot_r);
      end
      s3_v_r   <= s2_v_r;
      s3_cmd_r <= s2_cmd_r;
    end
  end

  // ---------------- stage 4: sum, round, subtract v ----------------
  logic signed [SUM_W-1:0] sum4  [3];
  logic signed [SUM_W-1:0] rnd4  [3];
  logic signed [ROT_W-1:0] rot_nxt [3];
  logic signed [ROT_W-1:0] rot_r [3];
  logic [CMD_W-1:0]        s4_cmd_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sum4[i]    = SUM_W'(pa_r[i]) - (SUM_W'(pb_r[i]) <<< 1) + (SUM_W'(pc_r[i]) <<< 1);
      rnd4[i]    = (sum4[i] + ROT_HALF) >>> ROT_SH;
      rot_nxt[i] = ROT_W'(signed'(rnd4[i][SH_W-1:0])) - ROT_W'(s3_v_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      rot_r    <= rot_nxt;
      s4_cmd_r <= s3_cmd_r;
    end
  end

  // ---------------- stage 5: scale ----------------
  logic signed [SCL_W-1:0]  scale5;
  logic signed [PROD_W-1:0] prod_r [3];

  always_comb begin
    unique case (cmd_t'(s4_cmd_r))
      CMD_LIN_VEL: scale5 = signed'({1'b0, lin_scale_r});
      CMD_ANG_VEL: scale5 = signed'({1'b0, ang_scale_r});
      CMD_GRAVITY: scale5 = SCL_UNITY;
      default:     scale5 = SCL_UNITY;   // undefined kind acts as gravity
    endcase
  end

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      for (int i = 0; i < 3; i++) begin
        prod_r[i] <= PROD_W'(rot_r[i]) * PROD_W'(scale5);
      end
    end
  end

  // ---------------- stage 6: round, clamp ----------------
  logic signed [PROD_W-1:0] val6 [3];
  logic signed [PROD_W-1:0] lim6;
  logic signed [DATA_W-1:0] res_nxt [3];
  logic                     clip_nxt;
  logic signed [DATA_W-1:0] res_r [3];
  logic                     clip_r;

  always_comb begin
    lim6     = PROD_W'(signed'({1'b0, clip_lim_r}));
    clip_nxt = 1'b0;
    for (int i = 0; i < 3; i++) begin
      val6[i] = (prod_r[i] + SCL_HALF) >>> SCALE_FRAC_BITS;
      priority if (val6[i] > lim6) begin
        res_nxt[i] = DATA_W'(lim6);
        clip_nxt   = 1'b1;
      end else if (val6[i] < -lim6) begin
        res_nxt[i] = DATA_W'(-lim6);
        clip_nxt   = 1'b1;
      end else begin
        res_nxt[i] = val6[i][DATA_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      res_r  <= res_nxt;
      clip_r <= clip_nxt;
    end
  end

  assign out_x       = res_r[0];
  assign out_y       = res_r[1];
  assign out_z       = res_r[2];
  assign out_clipped = clip_r;

endmodule

`default_nettype wire

>>> hw/rtl/qirsc_checker.sv
// ----------------------------------------------------------------------------
// qirsc_checker
// Port-level checks of the inverse quaternion rotator, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module qirsc_checker (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              in_valid,
  input wire logic                              in_stall,
  input wire logic                              cfg_valid,
  input wire logic                              cfg_ready,
  input wire logic                              out_valid,
  input wire logic                              out_stall,
  input wire logic signed [qirsc_pkg::DATA_W-1:0] out_x,
  input wire logic signed [qirsc_pkg::DATA_W-1:0] out_y,
  input wire logic signed [qirsc_pkg::DATA_W-1:0] out_z,
  input wire logic                              out_clipped
);

  import qirsc_pkg::*;

  localparam logic [DATA_W-1:0] MOST_NEG = {1'b1, {(DATA_W-1){1'b0}}};

  // A stalled result keeps its payload.
  `ASSERT_CLK(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_x) && $stable(out_y) && $stable(out_z) && $stable(out_clipped), "stalled result changed")

  // The clamp never produces the most negative code.
  `ASSERT_CLK(a_no_most_neg, out_valid |-> out_x != MOST_NEG && out_y != MOST_NEG && out_z != MOST_NEG, "result below -clip_limit")

  // Reset empties the pipeline.
  `ASSERT_CLK_ALWAYS(a_rst_empty, !rst_n |=> !out_valid && !in_stall, "pipeline not empty after reset")

  // An empty output stage cannot back-pressure the input.
  `ASSERT_CLK(a_no_stall_empty, !out_valid && $past(!out_valid) |-> !in_stall, "input stalled with empty output")

  // Register writes are never refused.
  `ASSERT_CLK(a_cfg_ready, cfg_valid |-> cfg_ready, "configuration write refused")

endmodule

bind quat_inverse_rotate_scale_clip qirsc_checker u_qirsc_checker (.*);

`default_nettype wire
